@@ src/lrg_pkg.sv @@
package lrg_pkg;

  localparam int ROW_BITS = 64;
  localparam int CFG_BITS = 7;

  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_TWO  = 2'd2;

  typedef struct packed {
    logic [ROW_BITS-1:0] row_cells;
    logic                first_row;
    logic                last_row;
  } in_req_t;

  typedef struct packed {
    logic [ROW_BITS-1:0] next_row_cells;
    logic                section_done;
  } out_req_t;

  // one column of the three-row window: above, middle, incoming
  typedef struct packed {
    logic up;
    logic mid;
    logic dn;
  } col_t;

endpackage

@@ src/life_row_generation.sv @@
// Row-streaming Life engine, rules B3/S23.
// Input channel (in_valid/in_stall/in_data): one board row per request.
//   A section is a top halo row (first_row), interior rows, then a bottom
//   halo row (last_row). Rows without an open section are dropped.
// Output channel (out_valid/out_stall/out_data): from the third row of a
//   section on, each input row yields the next generation of the row
//   before it; section_done marks the result caused by the bottom halo.
// Config channel (cfg_valid/cfg_ready/cfg_row_width): active row width,
//   clamped to 3..MAX_WIDTH; write only while idle. Always ready.
// Output: each result is registered, in the output register or the skid buffer.
// Throughput: one row per cycle while in_stall is low; each column is a
//   cell that updates in parallel from its two neighbor columns.
// Stall: an output register plus a one-entry skid buffer; in_stall rises
//   only when both are full, so a stalled receiver lets one more result
//   into the skid buffer before backpressure.
// Reset: synchronous active-low; no section open, width = MAX_WIDTH,
//   output and skid empty.
module life_row_generation
  import lrg_pkg::*;
#(
  parameter int MAX_WIDTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_req_t             in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_req_t            out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_BITS-1:0] cfg_row_width
);

  localparam int IW = $clog2(MAX_WIDTH);

  logic [IW-1:0]        last_idx_r;
  logic [IW-1:0]        last_idx_nxt;
  logic [1:0]           seen_r;
  logic [1:0]           seen_nxt;
  out_req_t             out_data_r;
  logic                 out_valid_r;
  out_req_t             skid_data_r;
  logic                 skid_valid_r;

  logic                 in_acc;
  logic                 load;
  logic                 produce;
  logic                 out_take;
  out_req_t             result;
  col_t                 cols [MAX_WIDTH];
  logic [MAX_WIDTH-1:0] nxt_row;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !in_stall;
  assign load      = in_acc && (in_data.first_row || (seen_r != SEEN_NONE));
  assign produce   = in_acc && !in_data.first_row && seen_r[1];
  assign out_take  = out_valid_r && !out_stall;

  always_comb begin
    if (cfg_row_width < CFG_BITS'(3)) begin
      last_idx_nxt = IW'(2);
    end else if (cfg_row_width > CFG_BITS'(MAX_WIDTH)) begin
      last_idx_nxt = IW'(MAX_WIDTH - 1);
    end else begin
      last_idx_nxt = IW'(cfg_row_width - CFG_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_idx_r <= IW'(MAX_WIDTH - 1);
    end else if (cfg_valid && cfg_ready) begin
      last_idx_r <= last_idx_nxt;
    end
  end

  always_comb begin
    seen_nxt = seen_r;
    if (in_acc) begin
      if (in_data.first_row) begin
        seen_nxt = SEEN_ONE;
      end else if (seen_r != SEEN_NONE) begin
        seen_nxt = in_data.last_row ? SEEN_NONE : SEEN_TWO;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= SEEN_NONE;
    end else begin
      seen_r <= seen_nxt;
    end
  end

  for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_cell
    col_t left;
    col_t right;

    if (k == 0) begin : g_left_wrap
      assign left = cols[last_idx_r];
    end else begin : g_left
      assign left = cols[k-1];
    end

    if (k == MAX_WIDTH - 1) begin : g_right_wrap
      assign right = cols[0];
    end else begin : g_right
      assign right = (last_idx_r == IW'(k)) ? cols[0] : cols[k+1];
    end

    lrg_cell u_cell (
      .clk      (clk),
      .load     (load),
      .clear_up (in_data.first_row),
      .dn_bit   (in_data.row_cells[k]),
      .active   (IW'(k) <= last_idx_r),
      .left     (left),
      .right    (right),
      .col      (cols[k]),
      .nxt_bit  (nxt_row[k])
    );
  end

  always_comb begin
    result.next_row_cells = ROW_BITS'(nxt_row);
    result.section_done   = in_data.last_row;
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      out_data_r <= skid_valid_r ? skid_data_r : result;
    end
    if (produce && out_valid_r && !out_take) begin
      skid_data_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      out_valid_r  <= skid_valid_r || produce;
      skid_valid_r <= 1'b0;
    end else if (produce) begin
      skid_valid_r <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ src/lrg_cell.sv @@
module lrg_cell
  import lrg_pkg::*;
(
  input  logic clk,
  input  logic load,
  input  logic clear_up,
  input  logic dn_bit,
  input  logic active,
  input  col_t left,
  input  col_t right,
  output col_t col,
  output logic nxt_bit
);

  logic       up_r;
  logic       mid_r;
  logic [3:0] nbr_cnt;

  always_ff @(posedge clk) begin
    if (load) begin
      up_r  <= clear_up ? 1'b0 : mid_r;
      mid_r <= dn_bit;
    end
  end

  always_comb begin
    col.up  = up_r;
    col.mid = mid_r;
    col.dn  = dn_bit;
  end

  always_comb begin
    nbr_cnt = 4'(left.up) + 4'(up_r) + 4'(right.up)
            + 4'(left.mid) + 4'(right.mid)
            + 4'(left.dn) + 4'(dn_bit) + 4'(right.dn);
    nxt_bit = active && ((nbr_cnt == 4'd3) || (mid_r && (nbr_cnt == 4'd2)));
  end

endmodule

@@ src/lrg_checker.sv @@
module lrg_checker
  import lrg_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input out_req_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result dropped or changed under stall");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  a_result_from_request: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result without an accepted row");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid && !in_stall)
    else $error("output not empty after reset");

endmodule

bind life_row_generation lrg_checker u_lrg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ tb/sv/life_row_generation_tb.sv @@
module life_row_generation_tb;
  import lrg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W = 64;
  localparam logic [ROW_BITS-1:0] ALL_ONES = '1;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_req_t             in_data;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_req_t            out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_BITS-1:0] cfg_row_width;

  // model of the block
  logic [ROW_BITS-1:0] win_above;
  logic [ROW_BITS-1:0] win_middle;
  logic [1:0]          win_seen;
  logic [CFG_BITS-1:0] win_width;
  out_req_t            pending_gens[$];

  bit idle_en = 1'b1;
  int fail_count;
  int rows_taken;
  int rows_dropped;
  int gens_checked;
  int width_writes;

  life_row_generation #(.MAX_WIDTH(MAX_W)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_row_width (cfg_row_width)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= idle_en && ($urandom_range(99) < 26);
  end

  function automatic int wrap_width(logic [CFG_BITS-1:0] w);
    int eff;
    eff = w;
    if (eff < 3) eff = 3;
    if (eff > MAX_W) eff = MAX_W;
    return eff;
  endfunction

  function automatic logic [ROW_BITS-1:0] life_next_row(logic [ROW_BITS-1:0] up,
                                                        logic [ROW_BITS-1:0] mid,
                                                        logic [ROW_BITS-1:0] dn,
                                                        int w);
    logic [ROW_BITS-1:0] res;
    int lft;
    int rgt;
    int n;
    res = '0;
    for (int k = 0; k < w; k++) begin
      lft = (k == 0) ? w - 1 : k - 1;
      rgt = (k == w - 1) ? 0 : k + 1;
      n = up[lft] + up[k] + up[rgt] + mid[lft] + mid[rgt] + dn[lft] + dn[k] + dn[rgt];
      if (mid[k] ? (n == 2 || n == 3) : (n == 3)) res[k] = 1'b1;
    end
    return res;
  endfunction

  function automatic void advance_window(in_req_t r);
    out_req_t gen;
    if (r.first_row) begin
      win_above  = '0;
      win_middle = r.row_cells;
      win_seen   = SEEN_ONE;
      rows_taken++;
    end else if (win_seen == SEEN_NONE) begin
      rows_dropped++;
    end else begin
      if (win_seen != SEEN_ONE) begin
        gen.next_row_cells = life_next_row(win_above, win_middle, r.row_cells,
                                           wrap_width(win_width));
        gen.section_done   = r.last_row;
        pending_gens.push_back(gen);
      end
      win_above  = win_middle;
      win_middle = r.row_cells;
      win_seen   = r.last_row ? SEEN_NONE : SEEN_TWO;
      rows_taken++;
    end
  endfunction

  // results checked before the same edge's input request updates the window
  always @(posedge clk) begin
    out_req_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_gens.size() == 0) begin
          $error("next_row_cells: unexpected result %h", out_data.next_row_cells);
          fail_count++;
        end else begin
          want = pending_gens.pop_front();
          gens_checked++;
          if (out_data.next_row_cells !== want.next_row_cells) begin
            $error("next_row_cells: expected %h, got %h",
                   want.next_row_cells, out_data.next_row_cells);
            fail_count++;
          end
          if (out_data.section_done !== want.section_done) begin
            $error("section_done: expected %b, got %b",
                   want.section_done, out_data.section_done);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) advance_window(in_data);
      if (cfg_valid && cfg_ready) win_width = cfg_row_width;
    end
  end

  function automatic logic [ROW_BITS-1:0] rand_row();
    logic [ROW_BITS-1:0] a;
    logic [ROW_BITS-1:0] b;
    logic [ROW_BITS-1:0] c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(3))
      0: return a;
      1: return a & b;
      2: return a & b & c;
      default: return a | b;
    endcase
  endfunction

  function automatic logic [CFG_BITS-1:0] pick_width();
    case ($urandom_range(9))
      0: return CFG_BITS'($urandom_range(0, 2));
      1: return CFG_BITS'($urandom_range(65, 127));
      2: return CFG_BITS'(64);
      3: return CFG_BITS'(3);
      default: return CFG_BITS'($urandom_range(3, 64));
    endcase
  endfunction

  // one row request; returns at a falling edge with valid still high
  task automatic send_row(input logic [ROW_BITS-1:0] cells, input logic first,
                          input logic last);
    in_req_t req;
    req.row_cells = cells;
    req.first_row = first;
    req.last_row  = last;
    while (idle_en && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (pending_gens.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_row_width(input logic [CFG_BITS-1:0] w);
    in_valid <= 1'b0;
    wait_idle();
    cfg_valid     <= 1'b1;
    cfg_row_width <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    width_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_corner_rows();
    send_row(ALL_ONES, 1'b0, 1'b0);                 // no open section: dropped
    send_row(ALL_ONES, 1'b1, 1'b1);                 // both marks: first wins
    send_row(ALL_ONES, 1'b0, 1'b0);
    send_row('0, 1'b0, 1'b0);
    send_row({32{2'b10}}, 1'b0, 1'b0);
    send_row({32{2'b01}}, 1'b0, 1'b1);
    send_row('0, 1'b1, 1'b0);                       // section without interior
    send_row('0, 1'b0, 1'b1);
    send_row(ALL_ONES, 1'b0, 1'b0);
    send_row('0, 1'b1, 1'b0);                       // cells across the wrap
    send_row(64'h8000_0000_0000_0001, 1'b0, 1'b0);
    send_row(64'h8000_0000_0000_0001, 1'b0, 1'b0);
    send_row(64'h8000_0000_0000_0001, 1'b0, 1'b0);
    send_row('0, 1'b0, 1'b1);
  endtask

  task automatic test_width_extremes();
    set_row_width('0);
    send_row(ALL_ONES, 1'b1, 1'b0);
    send_row(64'h2, 1'b0, 1'b0);
    send_row(ALL_ONES, 1'b0, 1'b0);
    set_row_width('1);                              // changed mid-section
    send_row(64'hF0F0_0000_0000_000F, 1'b0, 1'b0);
    set_row_width(CFG_BITS'(3));
    send_row(ALL_ONES, 1'b0, 1'b1);
    set_row_width(CFG_BITS'(1));
    set_row_width(CFG_BITS'(MAX_W));
  endtask

  task automatic test_random_sections();
    int base;
    int kind;
    base = rows_taken;
    idle_en = 1'b0;
    while (rows_taken - base < 450) begin
      if (rows_taken - base >= 150) idle_en = 1'b1;
      if ($urandom_range(7) == 0) set_row_width(pick_width());
      kind = $urandom_range(99);
      if (kind < 75) begin
        send_row(rand_row(), 1'b1, $urandom_range(9) == 0);
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(19) == 0) set_row_width(pick_width());
          send_row(rand_row(), 1'b0, 1'b0);
        end
        send_row(rand_row(), 1'b0, 1'b1);
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 3)) send_row(rand_row(), 1'b0, 1'b0);
      end else if (kind < 93) begin
        send_row(rand_row(), 1'b1, 1'b0);
        repeat ($urandom_range(0, 3)) send_row(rand_row(), 1'b0, 1'b0);
      end else begin
        send_row(rand_row(), 1'b1, 1'b0);
        send_row(rand_row(), 1'b0, 1'b1);
      end
    end
    idle_en = 1'b1;
  endtask

  initial begin
    int drain;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_row_width = CFG_BITS'(MAX_W);
    win_above     = '0;
    win_middle    = '0;
    win_seen      = SEEN_NONE;
    win_width     = CFG_BITS'(MAX_W);
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_corner_rows();
    test_width_extremes();
    test_random_sections();

    in_valid <= 1'b0;
    drain = 0;
    while (pending_gens.size() != 0 && drain < 5000) begin
      @(negedge clk);
      drain++;
    end
    repeat (5) @(negedge clk);
    if (pending_gens.size() != 0) begin
      $error("next_row_cells: %0d expected results never arrived", pending_gens.size());
      fail_count++;
    end

    $display("rows taken %0d, rows dropped %0d, next generations checked %0d",
             rows_taken, rows_dropped, gens_checked);
    $display("row width written %0d times, clamp extremes and mid-section changes included",
             width_writes);
    if (fail_count == 0) begin
      $display("life_row_generation_tb: clean");
    end else begin
      $display("life_row_generation_tb: errors");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("life_row_generation_tb: errors");
    $finish;
  end

endmodule
